>>> rtl/huffman_code_bit_packer_core_macros.svh
// Assertion macros used by the Huffman bit packer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCBP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hcbp_pkg;

    // Table geometry.
    localparam int SYMBOL_COUNT  = 256;
    localparam int MAX_CODE_BITS = 31;
    localparam int ADDR_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 5;
    localparam int CODE_W   = 31;
    localparam int BYTE_BITS = 8;
    localparam int VBITS_W  = 4;

    // Packer widths: up to 7 pending bits plus a 31-bit code.
    localparam int PEND_W   = 7;
    localparam int PCNT_W   = 3;
    localparam int ACC_W    = PEND_W + CODE_W;
    localparam int CNT_W    = 6;
    localparam int FULL_W   = 32;
    localparam int LEFT_W   = 3;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    // One code table entry.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_entry;

    // Request handed from the front end to the packer.
    typedef struct packed {
        logic take;
        logic flush;
    } t_req;

endpackage

>>> rtl/hcbp_table.sv
// Code table: synchronous memory with registered read data and per-entry valid bits.
// Depends on hcbp_pkg for geometry and the entry type.
`timescale 1ns / 1ps

module hcbp_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [hcbp_pkg::ADDR_W-1:0] i_wr_addr,
    input  hcbp_pkg::t_entry           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [hcbp_pkg::ADDR_W-1:0] i_rd_addr,
    output hcbp_pkg::t_entry           o_rd_data
);

    hcbp_pkg::t_entry                     r_mem [hcbp_pkg::SYMBOL_COUNT];
    logic [hcbp_pkg::SYMBOL_COUNT-1:0]    r_valid;
    hcbp_pkg::t_entry                     r_rd_data;
    logic                                 r_rd_hit;

    // Valid bits: reset marks every entry as an empty code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Memory read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // An entry never written reads as a zero-length code.
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

>>> rtl/hcbp_packer.sv
// Bit packer: merges table codes into the pending bits and emits bytes MSB first.
// Depends on hcbp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_core_macros.svh"

module hcbp_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hcbp_pkg::t_req                i_req,
    input  hcbp_pkg::t_entry              i_entry,
    output logic                          o_busy,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hcbp_pkg::BYTE_BITS-1:0] o_out_byte,
    output logic                          o_byte_present,
    output logic [hcbp_pkg::VBITS_W-1:0]  o_valid_bits,
    output logic                          o_is_final,
    output logic                          o_last
);

    // Lookup stage: holds the request whose table data the memory's read register presents.
    logic                               r_s1_vld;
    logic                               r_s1_flush;

    // Pending bits, right aligned.
    logic [hcbp_pkg::PEND_W-1:0]        r_pend;
    logic [hcbp_pkg::PCNT_W-1:0]        r_pcnt;

    // Emitter: holds the full bytes of one request; doubles as output register.
    logic [hcbp_pkg::LEFT_W-1:0]        r_em_left;
    logic [hcbp_pkg::FULL_W-1:0]        r_em_full;
    logic                               r_em_present;
    logic [hcbp_pkg::VBITS_W-1:0]       r_em_vbits;
    logic                               r_em_final;

    logic [hcbp_pkg::LEN_W-1:0]         w_clen;
    logic [hcbp_pkg::ACC_W-1:0]         w_acc;
    logic [hcbp_pkg::CNT_W-1:0]         w_cnt;
    logic [2:0]                         w_rem;
    logic [hcbp_pkg::LEFT_W-1:0]        w_nbytes;
    logic [hcbp_pkg::FULL_W-1:0]        w_full;
    logic [hcbp_pkg::BYTE_BITS:0]       w_keep;
    logic [hcbp_pkg::PEND_W-1:0]        w_new_pend;
    logic [hcbp_pkg::BYTE_BITS-1:0]     w_flush_byte;
    logic [hcbp_pkg::LEFT_W-1:0]        w_items;
    logic                               w_pop;
    logic                               w_em_free;
    logic                               w_s1_go;
    logic [1:0]                         w_idx;

    // Merge the looked-up code with the pending bits.
    assign w_clen     = r_s1_flush ? '0 : i_entry.len;
    assign w_acc      = (hcbp_pkg::ACC_W'(r_pend) << w_clen)
                        | hcbp_pkg::ACC_W'(i_entry.bits);
    assign w_cnt      = hcbp_pkg::CNT_W'(r_pcnt) + hcbp_pkg::CNT_W'(w_clen);
    assign w_rem      = w_cnt[2:0];
    assign w_nbytes   = w_cnt[hcbp_pkg::CNT_W-1:3];
    assign w_full     = hcbp_pkg::FULL_W'(w_acc >> w_rem);
    assign w_keep     = ({{hcbp_pkg::BYTE_BITS{1'b0}}, 1'b1} << w_rem)
                        - {{hcbp_pkg::BYTE_BITS{1'b0}}, 1'b1};
    assign w_new_pend = w_acc[hcbp_pkg::PEND_W-1:0] & w_keep[hcbp_pkg::PEND_W-1:0];

    // A flush pads the pending bits with zeros on the right.
    assign w_flush_byte = {1'b0, r_pend}
                          << (hcbp_pkg::VBITS_W'(hcbp_pkg::BYTE_BITS) - {1'b0, r_pcnt});

    // A flush always gives one result; an encode gives one per full byte.
    assign w_items = r_s1_flush ? hcbp_pkg::LEFT_W'(1) : w_nbytes;

    // Handshake of the emitter and the lookup stage.
    assign w_pop     = o_valid && !i_stall;
    assign w_em_free = (r_em_left == '0) || ((r_em_left == hcbp_pkg::LEFT_W'(1)) && w_pop);
    assign w_s1_go   = r_s1_vld && ((w_items == '0) || w_em_free);
    assign o_busy    = r_s1_vld && !w_s1_go;

    // Lookup stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s1_flush <= 1'b0;
        end else if (i_req.take) begin
            r_s1_vld   <= 1'b1;
            r_s1_flush <= i_req.flush;
        end else if (w_s1_go) begin
            r_s1_vld   <= 1'b0;
        end
    end

    // Pending bits update as each request leaves the lookup stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= '0;
        end else if (w_s1_go) begin
            if (r_s1_flush) begin
                r_pend <= '0;
                r_pcnt <= '0;
            end else begin
                r_pend <= w_new_pend;
                r_pcnt <= w_rem;
            end
        end
    end

    // Emitter count: load with the new request's bytes, count down on each pop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_left <= '0;
        end else if (w_s1_go && (w_items != '0)) begin
            r_em_left <= w_items;
        end else if (w_pop) begin
            r_em_left <= r_em_left - hcbp_pkg::LEFT_W'(1);
        end
    end

    // Emitter payload.
    always_ff @(posedge i_clk) begin
        if (w_s1_go && (w_items != '0)) begin
            r_em_final <= r_s1_flush;
            if (r_s1_flush) begin
                r_em_full    <= hcbp_pkg::FULL_W'(w_flush_byte);
                r_em_present <= (r_pcnt != '0);
                r_em_vbits   <= (r_pcnt != '0) ? hcbp_pkg::VBITS_W'(r_pcnt)
                                               : hcbp_pkg::VBITS_W'(hcbp_pkg::BYTE_BITS);
            end else begin
                r_em_full    <= w_full;
                r_em_present <= 1'b1;
                r_em_vbits   <= hcbp_pkg::VBITS_W'(hcbp_pkg::BYTE_BITS);
            end
        end
    end

    // The earliest remaining byte sits highest in the emitter word.
    assign w_idx          = r_em_left[1:0] - 2'd1;
    assign o_valid        = (r_em_left != '0);
    assign o_out_byte     = r_em_full[{w_idx, 3'b000} +: hcbp_pkg::BYTE_BITS];
    assign o_byte_present = r_em_present;
    assign o_valid_bits   = r_em_vbits;
    assign o_is_final     = r_em_final;
    assign o_last         = (r_em_left == hcbp_pkg::LEFT_W'(1));

    // Checks on the packer.
    `HCBP_ASSERT_IMP(a_left_range, i_clk, i_rst_n, 1'b1, r_em_left <= hcbp_pkg::LEFT_W'(4), "emitter holds more than four bytes")
    `HCBP_ASSERT_IMP(a_final_single, i_clk, i_rst_n, o_valid && o_is_final, o_last, "flush result is not the last result")
    `HCBP_ASSERT_IMP(a_encode_full, i_clk, i_rst_n, o_valid && !o_is_final, o_byte_present && (o_valid_bits == hcbp_pkg::VBITS_W'(hcbp_pkg::BYTE_BITS)), "encode byte is not a full byte")
    `HCBP_ASSERT_NXT(a_flush_clears, i_clk, i_rst_n, w_s1_go && r_s1_flush, r_pcnt == '0, "pending bits survive a flush")

endmodule

>>> rtl/huffman_code_bit_packer_core.sv
// Top level of the table-driven Huffman encoder with MSB-first byte packing.
// Depends on hcbp_pkg, hcbp_table and hcbp_packer.
`timescale 1ns / 1ps

// The block takes one request per clock cycle while o_stall is low. A load writes
// the code table and gives no result; an encode reads the table (registered read)
// and feeds the packer; a flush emits the padded final byte, with no byte present
// if no bits are pending. Results are registered in the lookup stage, then in the
// emitter. The packer hands out one byte per cycle while i_stall is low; an encode
// that completes k bytes (k up to four) makes a later byte-producing request wait
// in the lookup stage until they drain. Valid bits clear the table at reset, so no
// clearing pass is needed and the block takes requests in the first cycle after reset.
module huffman_code_bit_packer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [hcbp_pkg::KIND_W-1:0]    i_kind,
    input  logic [hcbp_pkg::SYM_W-1:0]     i_symbol,
    input  logic [hcbp_pkg::LEN_W-1:0]     i_code_length,
    input  logic [hcbp_pkg::CODE_W-1:0]    i_code_bits,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [hcbp_pkg::BYTE_BITS-1:0] o_out_byte,
    output logic                           o_byte_present,
    output logic [hcbp_pkg::VBITS_W-1:0]   o_valid_bits,
    output logic                           o_is_final,
    output logic                           o_last
);

    logic                              w_accept;
    logic                              w_in_range;
    logic [hcbp_pkg::ADDR_W-1:0]       w_addr;
    logic [hcbp_pkg::LEN_W-1:0]        w_len_sat;
    logic [hcbp_pkg::CODE_W:0]         w_mask;
    hcbp_pkg::t_entry                  w_wr_data;
    hcbp_pkg::t_entry                  w_rd_data;
    logic                              w_wr_en;
    logic                              w_rd_en;
    hcbp_pkg::t_req                    w_req;
    logic                              w_busy;

    // Request handshake.
    assign w_accept = i_valid && !o_stall;
    assign o_stall  = w_busy;

    // Symbols beyond the table are ignored on load and on encode.
    assign w_in_range = ({1'b0, i_symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT));
    assign w_addr     = i_symbol[hcbp_pkg::ADDR_W-1:0];

    // Saturate the length and drop code bits above it.
    assign w_len_sat = (i_code_length > hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_BITS))
                       ? hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_BITS) : i_code_length;
    assign w_mask    = ({{hcbp_pkg::CODE_W{1'b0}}, 1'b1} << w_len_sat)
                       - {{hcbp_pkg::CODE_W{1'b0}}, 1'b1};
    assign w_wr_data.len  = w_len_sat;
    assign w_wr_data.bits = i_code_bits & w_mask[hcbp_pkg::CODE_W-1:0];

    // Table access: loads write, encodes read.
    assign w_wr_en = w_accept && (i_kind == hcbp_pkg::KIND_LOAD) && w_in_range;
    assign w_rd_en = w_accept && (i_kind == hcbp_pkg::KIND_ENCODE);

    // Flushes and in-range encodes go to the packer; out-of-range encodes are dropped.
    assign w_req.take  = w_accept && ((i_kind == hcbp_pkg::KIND_FLUSH)
                         || ((i_kind == hcbp_pkg::KIND_ENCODE) && w_in_range));
    assign w_req.flush = (i_kind == hcbp_pkg::KIND_FLUSH);

    hcbp_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    hcbp_packer u_packer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (w_req),
        .i_entry        (w_rd_data),
        .o_busy         (w_busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_valid_bits   (o_valid_bits),
        .o_is_final     (o_is_final),
        .o_last         (o_last)
    );

endmodule
